// ===== sv/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, codes and round functions of the AES block cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXPAND = 5'b00010,
		ST_LOAD   = 5'b00100,
		ST_ROUND  = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_KLEN = 3'd4;
	localparam logic [2:0] REG_DIR  = 3'd5;

	localparam logic [1:0] KLEN_128  = 2'd0;
	localparam logic [1:0] KLEN_192  = 2'd1;
	localparam logic [1:0] KLEN_256  = 2'd2;
	localparam logic [1:0] KLEN_NONE = 2'd3;

	localparam logic [7:0] SBOX_FWD [256] = '{
	8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
	8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
	8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
	8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
	8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
	8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
	8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
	8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
	8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
	8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
	8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
	8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
	8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
	8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
	8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
	8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	localparam logic [7:0] SBOX_INV [256] = '{
	8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
	8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
	8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
	8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
	8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
	8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
	8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
	8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
	8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
	8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
	8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
	8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
	8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
	8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
	8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
	};

	function automatic logic [7:0] xt(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
	endfunction

	// byte n of the state sits at bits 127-8n; st[r+4c] is row r, column c
	function automatic logic [7:0] sb(input logic [127:0] s, input int n);
		return s[127-8*n -: 8];
	endfunction

	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] o;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[r+4*c] = SBOX_FWD[sb(s, r + 4*((c + r) & 3))];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			if (!last) begin
				t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
				t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
				t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
				t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
			end
		end
		for (int n = 0; n < 16; n++)
			o[127-8*n -: 8] = t[n];
		return o;
	endfunction

	function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
		logic [127:0] o;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[127-8*(r+4*c) -: 8] = SBOX_INV[sb(s, r + 4*((c - r + 4) & 3))];
		return o;
	endfunction

	function automatic logic [127:0] inv_mix(input logic [127:0] s);
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] m9 [4];
		logic [7:0] mb [4];
		logic [7:0] md [4];
		logic [7:0] me [4];
		logic [127:0] o;
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				a[j]  = sb(s, 4*c + j);
				x2[j] = xt(a[j]);
				x4[j] = xt(x2[j]);
				x8[j] = xt(x4[j]);
				m9[j] = x8[j] ^ a[j];
				mb[j] = x8[j] ^ x2[j] ^ a[j];
				md[j] = x8[j] ^ x4[j] ^ a[j];
				me[j] = x8[j] ^ x4[j] ^ x2[j];
			end
			o[127-8*(4*c)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
			o[127-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
			o[127-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
			o[127-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
		end
		return o;
	endfunction

endpackage

// ===== sv/aes_block_cipher.sv =====
// ----------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 encrypt or decrypt of one 128-bit block per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Configure over APB: key words at 0x00..0x18, key_length at 0x20,
//   direction at 0x28 (1 = encrypt). Write only while the block is idle.
//   s_tdata carries a block; m_tdata returns the result, m_tuser = ok.
// Block flow:
//   After a key or key length change the first block first expands the key
//   into the round-key memory, one 32-bit word a cycle: 44, 52 or 60 words.
//   Each block then passes the load state, the round datapath for the first
//   key addition and each of 10, 12 or 14 rounds (one round per cycle, key
//   read ahead from the registered memory port) and the done state, which
//   loads the output register; the next beat is taken only once the block
//   is back in idle. With key_length unset the beat goes straight to the
//   done state, which loads the result (zero, ok low).
// Reset:
//   Key words clear, key_length reads not set up, direction decrypt; the
//   round-key memory is marked stale and refilled on the next block.
// Stall:
//   A result holds on m_tdata while m_tready is low; the next block may be
//   taken and worked on, and it waits for the output register to free up.
// ----------------------------------------------------------------------------
module aes_block_cipher (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // block_high [63:0], block_low [127:64]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // result_high [63:0], result_low [127:64]
	output logic         m_tuser    // ok
);

	logic [63:0] key0_q, key1_q, key2_q, key3_q;
	logic [1:0]  klen_q;
	logic        dir_q;
	logic        stale_q;

	aes_pkg::state_t state_q;

	logic [127:0] st_q;
	logic         ok_q;
	logic [3:0]   k_q;
	logic [3:0]   rd_addr;
	logic [127:0] rk_q;
	logic [127:0] rkmem [16];

	logic [5:0]   wi_q;
	logic [2:0]   wj_q;
	logic [31:0]  win_q [8];
	logic [95:0]  line_q;
	logic [7:0]   rc_q;

	logic [2:0] reg_idx;
	logic       wr_en;
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel & penable & pwrite & pready;
	assign pready  = 1'b1;

	always_comb begin
		unique case (reg_idx)
			aes_pkg::REG_KEY0: prdata = key0_q;
			aes_pkg::REG_KEY1: prdata = key1_q;
			aes_pkg::REG_KEY2: prdata = key2_q;
			aes_pkg::REG_KEY3: prdata = key3_q;
			aes_pkg::REG_KLEN: prdata = {62'd0, klen_q};
			aes_pkg::REG_DIR:  prdata = {63'd0, dir_q};
			default:           prdata = 64'd0;
		endcase
	end

	// round count, and key words and total expanded words (each less one), for the key length
	logic [3:0] rounds;
	logic [2:0] nk_m1;
	logic [5:0] total_m1;
	assign rounds   = 4'd10 + {1'b0, klen_q, 1'b0};
	assign nk_m1    = 3'd3 + {klen_q, 1'b0};
	assign total_m1 = {rounds, 2'b11};

	// key expansion: next word from the key registers, then from the window of recent words
	logic [255:0] key_all;
	logic [31:0]  kw, kt, new_word;
	assign key_all = {key0_q, key1_q, key2_q, key3_q};
	always_comb begin
		kw = key_all[255 - 32*wi_q[2:0] -: 32];
		kt = win_q[0];
		if (wj_q == 3'd0)
			kt = aes_pkg::sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rc_q, 24'd0};
		else if (klen_q == aes_pkg::KLEN_256 && wj_q == 3'd4)
			kt = aes_pkg::sub_word(win_q[0]);
		new_word = (wi_q <= {3'd0, nk_m1}) ? kw : (win_q[nk_m1] ^ kt);
	end

	logic [3:0] next_addr;
	always_comb begin
		if (dir_q)
			next_addr = k_q + 4'd1;
		else
			next_addr = rounds - k_q - 4'd1;
	end

	// address the key for the coming round cycle
	always_comb begin
		if (state_q == aes_pkg::ST_LOAD)
			rd_addr = dir_q ? 4'd0 : rounds;
		else
			rd_addr = next_addr;
	end

	logic [127:0] round_out;
	always_comb begin
		priority if (k_q == 4'd0)
			round_out = st_q ^ rk_q;
		else if (dir_q)
			round_out = aes_pkg::enc_round(st_q, k_q == rounds) ^ rk_q;
		else if (k_q == rounds)
			round_out = aes_pkg::inv_shift_sub(st_q) ^ rk_q;
		else
			round_out = aes_pkg::inv_mix(aes_pkg::inv_shift_sub(st_q) ^ rk_q);
	end

	// round-key memory: one write port for expansion, one registered read
	always_ff @(posedge clk) begin
		if (state_q == aes_pkg::ST_EXPAND && wi_q[1:0] == 2'b11)
			rkmem[wi_q[5:2]] <= {line_q, new_word};
		rk_q <= rkmem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0;
			key1_q <= '0;
			key2_q <= '0;
			key3_q <= '0;
			klen_q <= aes_pkg::KLEN_NONE;
			dir_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				aes_pkg::REG_KEY0: key0_q <= pwdata;
				aes_pkg::REG_KEY1: key1_q <= pwdata;
				aes_pkg::REG_KEY2: key2_q <= pwdata;
				aes_pkg::REG_KEY3: key3_q <= pwdata;
				aes_pkg::REG_KLEN: klen_q <= pwdata[1:0];
				aes_pkg::REG_DIR:  dir_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	assign s_tready = (state_q == aes_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= aes_pkg::ST_IDLE;
			stale_q  <= 1'b1;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= 1'b0;
			st_q     <= '0;
			ok_q     <= 1'b0;
			rc_q     <= '0;
			win_q    <= '{default: '0};
			line_q   <= '0;
			wi_q     <= '0;
			wj_q     <= '0;
			k_q      <= '0;
		end else begin
			// the done state reloads the output register itself
			if (m_tvalid && m_tready && state_q != aes_pkg::ST_DONE)
				m_tvalid <= 1'b0;
			if (wr_en && reg_idx != aes_pkg::REG_DIR)
				stale_q <= 1'b1;
			else if (state_q == aes_pkg::ST_EXPAND && wi_q == total_m1)
				stale_q <= 1'b0;
			unique case (state_q)
				aes_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						wi_q <= '0;
						wj_q <= '0;
						rc_q <= 8'h01;
						if (klen_q == aes_pkg::KLEN_NONE) begin
							st_q    <= '0;
							ok_q    <= 1'b0;
							state_q <= aes_pkg::ST_DONE;
						end else begin
							st_q <= {s_tdata[63:0], s_tdata[127:64]};
							if (stale_q)
								state_q <= aes_pkg::ST_EXPAND;
							else
								state_q <= aes_pkg::ST_LOAD;
						end
					end
				end
				aes_pkg::ST_EXPAND: begin
					for (int n = 7; n > 0; n--)
						win_q[n] <= win_q[n-1];
					win_q[0] <= new_word;
					line_q   <= {line_q[63:0], new_word};
					if (wj_q == 3'd0 && wi_q > {3'd0, nk_m1})
						rc_q <= aes_pkg::xt(rc_q);
					wj_q <= (wj_q == nk_m1) ? 3'd0 : wj_q + 3'd1;
					wi_q <= wi_q + 6'd1;
					if (wi_q == total_m1)
						state_q <= aes_pkg::ST_LOAD;
				end
				aes_pkg::ST_LOAD: begin
					k_q     <= '0;
					ok_q    <= 1'b1;
					state_q <= aes_pkg::ST_ROUND;
				end
				aes_pkg::ST_ROUND: begin
					st_q <= round_out;
					k_q  <= k_q + 4'd1;
					if (k_q == rounds)
						state_q <= aes_pkg::ST_DONE;
				end
				aes_pkg::ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tdata  <= {st_q[63:0], st_q[127:64]};
						m_tuser  <= ok_q;
						m_tvalid <= 1'b1;
						state_q  <= aes_pkg::ST_IDLE;
					end
				end
				default: state_q <= aes_pkg::ST_IDLE;
			endcase
		end
	end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for aes_block_cipher: an in-bench AES model predicts
// every result beat, which is checked in order against the master side.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic [63:0] res_high;
		logic [63:0] res_low;
		logic        ok;
	} cipher_result_t;

	// Scoreboard: own copy of the key registers and a queue of predicted results
	class cipher_scoreboard;
		logic [63:0] key_w [4];
		logic [1:0]  klen;
		logic        encrypt;
		cipher_result_t predicted [$];
		int unsigned errors;

		function new();
			foreach (key_w[i]) key_w[i] = '0;
			klen = aes_pkg::KLEN_NONE;
			encrypt = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(int idx, logic [63:0] val);
			case (idx)
				aes_pkg::REG_KEY0: key_w[0] = val;
				aes_pkg::REG_KEY1: key_w[1] = val;
				aes_pkg::REG_KEY2: key_w[2] = val;
				aes_pkg::REG_KEY3: key_w[3] = val;
				aes_pkg::REG_KLEN: klen = val[1:0];
				aes_pkg::REG_DIR:  encrypt = val[0];
				default: ;
			endcase
		endfunction

		function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
			logic [7:0] p;
			p = '0;
			for (int k = 0; k < 8; k++) begin
				if (b[k]) p ^= a;
				a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
			end
			return p;
		endfunction

		// Predict one block and queue the result
		function void note_block(logic [63:0] blk_high, logic [63:0] blk_low);
			logic [7:0] key [32];
			logic [7:0] ks [240];
			logic [7:0] st [16];
			logic [7:0] tmp [16];
			logic [7:0] t [4];
			logic [7:0] t0;
			logic [7:0] rcon [11];
			logic [7:0] mf [4];
			logic [7:0] mi [4];
			logic [7:0] a [4];
			logic [7:0] v;
			logic [127:0] blk;
			cipher_result_t res;
			int nk, rounds, src, rk;
			rcon = '{8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
				8'h1B, 8'h36};
			mf = '{8'h02, 8'h03, 8'h01, 8'h01};
			mi = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
			if (klen == aes_pkg::KLEN_NONE) begin
				res = '{64'd0, 64'd0, 1'b0};
				predicted.push_back(res);
				return;
			end
			nk = (klen == aes_pkg::KLEN_128) ? 4 : (klen == aes_pkg::KLEN_192) ? 6 : 8;
			rounds = nk + 6;
			for (int w = 0; w < 4; w++)
				for (int k = 0; k < 8; k++)
					key[8*w+k] = key_w[w][63-8*k -: 8];
			for (int k = 0; k < 4*nk; k++) ks[k] = key[k];
			for (int i = nk; i < 4*(rounds+1); i++) begin
				for (int b = 0; b < 4; b++) t[b] = ks[4*(i-1)+b];
				if (i % nk == 0) begin
					t0 = t[0];
					t[0] = aes_pkg::SBOX_FWD[t[1]] ^ rcon[i/nk];
					t[1] = aes_pkg::SBOX_FWD[t[2]];
					t[2] = aes_pkg::SBOX_FWD[t[3]];
					t[3] = aes_pkg::SBOX_FWD[t0];
				end else if (nk > 6 && i % nk == 4) begin
					for (int b = 0; b < 4; b++) t[b] = aes_pkg::SBOX_FWD[t[b]];
				end
				for (int b = 0; b < 4; b++) ks[4*i+b] = ks[4*(i-nk)+b] ^ t[b];
			end
			blk = {blk_high, blk_low};
			for (int n = 0; n < 16; n++) st[n] = blk[127-8*n -: 8];
			for (int step = 0; step <= rounds; step++) begin
				rk = encrypt ? step : rounds - step;
				if (step > 0) begin
					// shift rows, then substitute
					for (int c = 0; c < 4; c++)
						for (int r = 0; r < 4; r++) begin
							src = encrypt ? (c + r) & 3 : (c - r + 4) & 3;
							tmp[r+4*c] = st[r+4*src];
						end
					for (int n = 0; n < 16; n++)
						st[n] = encrypt ? aes_pkg::SBOX_FWD[tmp[n]] : aes_pkg::SBOX_INV[tmp[n]];
					// forward mix before the key, inverse mix after it
					if (encrypt && step < rounds) begin
						for (int c = 0; c < 4; c++) begin
							for (int j = 0; j < 4; j++) a[j] = st[4*c+j];
							for (int r = 0; r < 4; r++) begin
								v = '0;
								for (int j = 0; j < 4; j++) v ^= gmul(a[j], mf[(j-r+4)&3]);
								st[4*c+r] = v;
							end
						end
					end
				end
				for (int n = 0; n < 16; n++) st[n] ^= ks[16*rk+n];
				if (!encrypt && step > 0 && step < rounds) begin
					for (int c = 0; c < 4; c++) begin
						for (int j = 0; j < 4; j++) a[j] = st[4*c+j];
						for (int r = 0; r < 4; r++) begin
							v = '0;
							for (int j = 0; j < 4; j++) v ^= gmul(a[j], mi[(j-r+4)&3]);
							st[4*c+r] = v;
						end
					end
				end
			end
			for (int n = 0; n < 16; n++) blk[127-8*n -: 8] = st[n];
			res = '{blk[127:64], blk[63:0], 1'b1};
			predicted.push_back(res);
		endfunction

		function void check_result(logic [63:0] r_high, logic [63:0] r_low, logic r_ok);
			cipher_result_t e;
			if (predicted.size() == 0) begin
				$display("%0t: unexpected result beat %h_%h ok=%b", $time, r_high, r_low, r_ok);
				errors++;
				return;
			end
			e = predicted.pop_front();
			if (r_high !== e.res_high) begin
				$display("%0t: result_high expected %h actual %h", $time, e.res_high, r_high);
				errors++;
			end
			if (r_low !== e.res_low) begin
				$display("%0t: result_low expected %h actual %h", $time, e.res_low, r_low);
				errors++;
			end
			if (r_ok !== e.ok) begin
				$display("%0t: ok expected %b actual %b", $time, e.ok, r_ok);
				errors++;
			end
		endfunction

		function int pending();
			return predicted.size();
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         psel, penable, pwrite;
	logic [5:0]   paddr;
	logic [63:0]  pwdata;
	logic [63:0]  prdata;
	logic         pready;
	logic         s_tvalid, s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid, m_tready;
	logic [127:0] m_tdata;
	logic         m_tuser;

	cipher_scoreboard sb = new();
	bit quiet;      // no idling on either side while set

	aes_block_cipher dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: stall about a quarter of the cycles unless quiet
	always @(negedge clk) begin
		m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 25);
	end

	// Check every accepted result beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[63:0], m_tdata[127:64], m_tuser);
	end

	task automatic apb_write(int idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= 6'(idx * 8); pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Drop valid, drain all results, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_key(logic [1:0] kl, logic dir, logic [63:0] k0, logic [63:0] k1,
		logic [63:0] k2, logic [63:0] k3);
		drain();
		apb_write(aes_pkg::REG_KEY0, k0);
		apb_write(aes_pkg::REG_KEY1, k1);
		apb_write(aes_pkg::REG_KEY2, k2);
		apb_write(aes_pkg::REG_KEY3, k3);
		apb_write(aes_pkg::REG_KLEN, {62'd0, kl});
		apb_write(aes_pkg::REG_DIR, {63'd0, dir});
	endtask

	// Send one block: optional idle gap, raise valid, hold until accepted.
	// Valid stays high afterwards; the next call or a drain moves it on.
	task automatic send_block(logic [63:0] hi, logic [63:0] lo);
		if (!quiet && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {lo, hi};
		do @(posedge clk); while (!s_tready);
		sb.note_block(hi, lo);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] rand_pattern();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			3: return ~(64'd1 << $urandom_range(0, 63));
			default: return rand64();
		endcase
	endfunction

	initial begin
		logic [1:0] kl;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
		quiet = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Key not set up after reset: zero result, ok low
		send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF);
		send_block('1, '1);

		// Standard 128-bit key, encrypt then decrypt
		set_key(aes_pkg::KLEN_128, 1'b1, 64'h0001020304050607, 64'h08090A0B0C0D0E0F,
			'1, '1);
		send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF);
		send_block(64'd0, 64'd0);
		send_block('1, '1);
		send_block(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
		drain();
		apb_write(aes_pkg::REG_DIR, 64'd0);
		send_block(64'h69C4E0D86A7B0430, 64'hD8CDB78070B4C55A);
		send_block('1, 64'd0);

		// 192-bit key; unused key bytes hold junk
		set_key(aes_pkg::KLEN_192, 1'b1, 64'h0001020304050607, 64'h08090A0B0C0D0E0F,
			64'h1011121314151617, 64'hDEADBEEFDEADBEEF);
		send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF);
		send_block(64'd1, 64'h8000000000000000);
		drain();
		apb_write(aes_pkg::REG_DIR, 64'd0);
		send_block(64'hDDA97CA4864CDFE0, 64'h6EAF70A0EC0D7191);

		// 256-bit key, both directions, with all-ones key
		set_key(aes_pkg::KLEN_256, 1'b1, 64'h0001020304050607, 64'h08090A0B0C0D0E0F,
			64'h1011121314151617, 64'h18191A1B1C1D1E1F);
		send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF);
		drain();
		apb_write(aes_pkg::REG_DIR, 64'd0);
		send_block(64'h8EA2B7CA516745BF, 64'hEAFC49904B496089);
		set_key(aes_pkg::KLEN_256, 1'b0, '1, '1, '1, '1);
		send_block(64'd0, '1);
		drain();
		apb_write(aes_pkg::REG_DIR, '1);
		send_block(64'd0, '1);

		// Writes above the last register change no register; upper value bits are masked
		drain();
		apb_write(6, '1);
		apb_write(7, '1);
		apb_write(aes_pkg::REG_KLEN, 64'hFFFF_FFFF_FFFF_FFFC);
		send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
		drain();
		apb_write(aes_pkg::REG_KLEN, '1);
		send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);

		// Random phases: fresh key and direction, then a burst of blocks
		for (int ph = 0; ph < 14; ph++) begin
			kl = ($urandom_range(0, 9) == 0) ? aes_pkg::KLEN_NONE : 2'($urandom_range(0, 2));
			set_key(kl, 1'($urandom_range(0, 1)), rand_pattern(), rand_pattern(),
				rand_pattern(), rand_pattern());
			quiet = (ph == 5);
			for (int i = 0; i < 66; i++) begin
				send_block(rand_pattern(), rand_pattern());
				// Hold off once until every result is back
				if (ph == 3 && i == 30) begin
					drain();
					@(negedge clk);
				end
			end
			quiet = 1'b0;
		end

		drain();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#30000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== aes_block_cipher.f =====
sv/aes_pkg.sv
sv/aes_block_cipher.sv
test/testbench.sv
